FILE: hdl/met_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// Used by every module under hdl/; depends on nothing.
package met_pkg;

	localparam int Q_W        = 32;
	localparam int STEP_W     = 31;
	localparam int ITER_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SAT_IN_W   = 65;
	localparam int PROD_W     = 64;

	localparam int FRAC_BITS_DEF  = 28;
	localparam int INDEX_BITS_DEF = 12;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

	localparam logic signed [Q_W-1:0] RST_ORIGIN_REAL = -32'sd671088640;
	localparam logic signed [Q_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;
	localparam logic [STEP_W-1:0]     RST_STEP_REAL   = 31'd1342177;
	localparam logic [STEP_W-1:0]     RST_STEP_IMAG   = 31'd1789570;
	localparam logic [ITER_W-1:0]     RST_MAX_ITER    = 16'd5000;

	localparam logic signed [SAT_IN_W-1:0] Q_MAX_EXT = 65'sd2147483647;
	localparam logic signed [SAT_IN_W-1:0] Q_MIN_EXT = -65'sd2147483648;

	typedef struct packed {
		logic signed [Q_W-1:0] origin_real;
		logic signed [Q_W-1:0] origin_imag;
		logic [STEP_W-1:0]     step_real;
		logic [STEP_W-1:0]     step_imag;
		logic [ITER_W-1:0]     max_iterations;
	} cfg_t;

	typedef struct packed {
		logic signed [Q_W-1:0] re;
		logic signed [Q_W-1:0] im;
	} cpoint_t;

	// Clamp a wide signed value into the 32-bit fixed-point range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX_EXT) begin
			r = Q_MAX_EXT[Q_W-1:0];
		end else if (v < Q_MIN_EXT) begin
			r = Q_MIN_EXT[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/met_front.sv
// Front end: takes pixel requests and maps them to the complex point c.
// Depends on met_pkg; feeds met_queue.
module met_front #(
	parameter int INDEX_BITS = met_pkg::INDEX_BITS_DEF
) (
	input  logic                  start,
	input  logic [INDEX_BITS-1:0] pixel_column,
	input  logic [INDEX_BITS-1:0] pixel_row,
	input  met_pkg::cfg_t         cfg,
	input  logic                  full,
	output logic                  busy,
	output logic                  push,
	output met_pkg::cpoint_t      push_data
);

	localparam int PW = met_pkg::STEP_W + INDEX_BITS;

	logic [PW-1:0]                              prod_re;
	logic [PW-1:0]                              prod_im;
	logic signed [met_pkg::SAT_IN_W-1:0]        sum_re;
	logic signed [met_pkg::SAT_IN_W-1:0]        sum_im;

	assign prod_re = pixel_column * cfg.step_real;
	assign prod_im = pixel_row * cfg.step_imag;

	assign sum_re = met_pkg::SAT_IN_W'(cfg.origin_real)
		+ $signed({{(met_pkg::SAT_IN_W-PW){1'b0}}, prod_re});
	assign sum_im = met_pkg::SAT_IN_W'(cfg.origin_imag)
		+ $signed({{(met_pkg::SAT_IN_W-PW){1'b0}}, prod_im});

	assign busy         = full;
	assign push         = start & ~full;
	assign push_data.re = met_pkg::sat_q(sum_re);
	assign push_data.im = met_pkg::sat_q(sum_im);

endmodule

FILE: hdl/met_queue.sv
// Two-entry queue of complex points between the front end and the core.
// Depends on met_pkg.
module met_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  met_pkg::cpoint_t push_data,
	input  logic             pop,
	output met_pkg::cpoint_t pop_data,
	output logic             full,
	output logic             empty
);

	met_pkg::cpoint_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/met_core.sv
// Iteration core: runs z = z*z + c, one multiply phase and one update phase
// per iteration. Depends on met_pkg; takes points from met_queue.
module met_core #(
	parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  met_pkg::cpoint_t             pop_data,
	input  logic [met_pkg::ITER_W-1:0]   max_iterations,
	output logic                         pop,
	output logic                         done,
	output logic [met_pkg::ITER_W-1:0]   escape_iteration,
	output logic                         escaped
);

	localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam logic [met_pkg::PROD_W-1:0] ESC_LIMIT =
		(ESC_SHIFT < met_pkg::PROD_W) ? (64'd1 << ESC_SHIFT) : '1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                              state_q;
	met_pkg::cpoint_t                        c_q;
	met_pkg::cpoint_t                        z_q;
	logic [met_pkg::ITER_W-1:0]              it_q;
	logic                                    chk_q;
	logic signed [met_pkg::PROD_W-1:0]       p_rr_q;
	logic signed [met_pkg::PROD_W-1:0]       p_ii_q;
	logic signed [met_pkg::PROD_W-1:0]       p_ri_q;
	logic                                    done_q;
	logic [met_pkg::ITER_W-1:0]              esc_it_q;
	logic                                    esc_q;

	logic signed [met_pkg::PROD_W-1:0]       diff;
	logic signed [met_pkg::PROD_W-1:0]       sh_re;
	logic signed [met_pkg::PROD_W-1:0]       sh_im;
	logic [met_pkg::PROD_W-1:0]              mag;
	logic                                    over;
	met_pkg::cpoint_t                        z_next;

	assign diff  = p_rr_q - p_ii_q;
	assign sh_re = diff >>> FRAC_BITS;
	assign sh_im = p_ri_q >>> (FRAC_BITS - 1);
	assign mag   = $unsigned(p_rr_q) + $unsigned(p_ii_q);
	assign over  = chk_q && (mag > ESC_LIMIT);

	assign z_next.re = met_pkg::sat_q(met_pkg::SAT_IN_W'(sh_re)
		+ met_pkg::SAT_IN_W'(c_q.re));
	assign z_next.im = met_pkg::sat_q(met_pkg::SAT_IN_W'(sh_im)
		+ met_pkg::SAT_IN_W'(c_q.im));

	assign pop              = (state_q == ST_IDLE) && !empty;
	assign done             = done_q;
	assign escape_iteration = esc_it_q;
	assign escaped          = esc_q;

	// Point load on pop, products of the current z, z update and result; the squares also serve the escape test of z.
	always_ff @(posedge clk) begin
		if (pop) begin
			c_q     <= pop_data;
			z_q     <= '0;
			chk_q   <= 1'b0;
			it_q    <= '0;
		end
		if (state_q == ST_MUL) begin
			p_rr_q <= z_q.re * z_q.re;
			p_ii_q <= z_q.im * z_q.im;
			p_ri_q <= z_q.re * z_q.im;
		end
		if (state_q == ST_UPD && !over && it_q != max_iterations) begin
			z_q   <= z_next;
			it_q  <= it_q + 1'b1;
			chk_q <= 1'b1;
		end
		if (state_q == ST_UPD) begin
			esc_q    <= over;
			esc_it_q <= over ? it_q - 1'b1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (over || it_q == max_iterations) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time block: configuration registers, front end,
// point queue and iteration core. Depends on met_pkg, met_front, met_queue, met_core.
//
// Usage. A request names one pixel by pixel_column and pixel_row and is taken
// at a rising edge where start is high and busy is low. The front end maps it
// to c = origin + index * step (saturated to the signed 32-bit fixed-point
// range) in the same cycle and drops c into a two-entry queue; busy is high
// only while that queue is full. The core pulls one point at a time and
// iterates z = z*z + c. Each iteration forms the three 32x32 products of z in
// ST_MUL, then in ST_UPD tests |z|^2 of that z against 4 and forms the new z.
// That shared multiplier loop sets the rate. A point that has not escaped
// when the count reaches max_iterations is reported as inside.
// Each result appears for exactly one cycle with done high, together with
// escape_iteration and escaped; the receiver cannot stall it. Exactly one
// result comes back per request, in request order.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this. Unknown
// indexes are ignored. Reset clears the queue and the core and loads the
// default view and a limit of 5000 iterations.
module mandelbrot_escape_time_top #(
	parameter int FRAC_BITS  = met_pkg::FRAC_BITS_DEF,
	parameter int INDEX_BITS = met_pkg::INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [INDEX_BITS-1:0]             pixel_column,
	input  logic [INDEX_BITS-1:0]             pixel_row,
	output logic                              done,
	output logic [met_pkg::ITER_W-1:0]        escape_iteration,
	output logic                              escaped,
	input  logic                              cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data
);

	met_pkg::cfg_t    cfg_q;
	logic             push;
	met_pkg::cpoint_t push_data;
	logic             pop;
	met_pkg::cpoint_t pop_data;
	logic             full;
	logic             empty;

	// Register file. Steps keep their low 31 bits, the limit its low 16 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real    <= met_pkg::RST_ORIGIN_REAL;
			cfg_q.origin_imag    <= met_pkg::RST_ORIGIN_IMAG;
			cfg_q.step_real      <= met_pkg::RST_STEP_REAL;
			cfg_q.step_imag      <= met_pkg::RST_STEP_IMAG;
			cfg_q.max_iterations <= met_pkg::RST_MAX_ITER;
		end else if (cfg_we) begin
			case (cfg_index)
				met_pkg::REG_ORIGIN_REAL: cfg_q.origin_real <= $signed(cfg_data);
				met_pkg::REG_ORIGIN_IMAG: cfg_q.origin_imag <= $signed(cfg_data);
				met_pkg::REG_STEP_REAL: begin
					cfg_q.step_real <= cfg_data[met_pkg::STEP_W-1:0];
				end
				met_pkg::REG_STEP_IMAG: begin
					cfg_q.step_imag <= cfg_data[met_pkg::STEP_W-1:0];
				end
				met_pkg::REG_MAX_ITERATIONS: begin
					cfg_q.max_iterations <= cfg_data[met_pkg::ITER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	met_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.start       (start),
		.pixel_column(pixel_column),
		.pixel_row   (pixel_row),
		.cfg         (cfg_q),
		.full        (full),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data)
	);

	met_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (full),
		.empty    (empty)
	);

	met_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.pop_data        (pop_data),
		.max_iterations  (cfg_q.max_iterations),
		.pop             (pop),
		.done            (done),
		.escape_iteration(escape_iteration),
		.escaped         (escaped)
	);

endmodule

FILE: hdl/met_checker.sv
// Port-level checker for the Mandelbrot escape-time block, bound to the top.
// Depends on met_pkg and mandelbrot_escape_time_top.
module met_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [met_pkg::ITER_W-1:0]     escape_iteration,
	input logic                           escaped
);

	// Requests taken but not yet answered: at most two queued plus one in work.
	logic [2:0] pending_q;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (accept && !done) begin
			pending_q <= pending_q + 3'd1;
		end else if (done && !accept) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pending_q != 3'd0))
		else $error("result without an open request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more open requests than the block can hold");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 3'd3) |-> busy)
		else $error("request could be taken with no room left");

	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !escaped) |-> (escape_iteration == '0))
		else $error("point inside the set reported a nonzero iteration");

endmodule

bind mandelbrot_escape_time_top met_checker u_met_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.escape_iteration(escape_iteration),
	.escaped         (escaped)
);
